// ----- rtl/lcr_pkg.sv -----
// Package for the LED current range and enable block.
// Holds payload structs, codes, controller types and the range limit table.
// No dependencies.
package lcr_pkg;

	localparam int CODE_BITS_DEF = 12;
	localparam int LOAD_W        = 24;
	localparam int MULT_W        = 6;
	localparam int BASE_W        = 18;
	localparam int LIMIT_W       = 24;
	localparam int RANGE_W       = 3;
	localparam int CUR_W         = 12;

	localparam logic [RANGE_W-1:0] TOP_RANGE   = 3'd7;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 3'd3;
	localparam logic [LIMIT_W-1:0] TOP_LIMIT   = 24'd160000;
	localparam logic [MULT_W-1:0]  MULT_RESET  = 6'd1;

	// Configuration register indexes.
	localparam logic CFG_MULT = 1'b0;
	localparam logic CFG_MODE = 1'b1;

	typedef enum logic [1:0] {
		ACT_ENABLE  = 2'd0,
		ACT_DISABLE = 2'd1,
		ACT_SET     = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PWR_NONE = 2'd0,
		PWR_UP   = 2'd1,
		PWR_DOWN = 2'd2
	} power_event_t;

	typedef struct packed {
		action_t           action;
		logic              channel;
		logic [LOAD_W-1:0] load_ua;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [RANGE_W-1:0] range_code;
		logic [CUR_W-1:0]   current_code;
		logic               channel_enabled;
		logic               chip_on;
		logic [1:0]         power_event;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LIMIT,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic lim_load;
		logic idx_inc;
		logic div_start;
		logic use_top;
		logic div_step;
		logic set_err;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_set;
		logic scaled;
		logic below;
		logic last_idx;
		logic div_done;
		logic out_busy;
	} sts_t;

	// Unscaled range limits in microamps.
	function automatic logic [BASE_W-1:0] base_limit(input logic [RANGE_W-1:0] idx);
		logic [BASE_W-1:0] lim;
		unique case (idx)
			3'd0: lim = 18'd5000;
			3'd1: lim = 18'd10000;
			3'd2: lim = 18'd20000;
			3'd3: lim = 18'd40000;
			3'd4: lim = 18'd80000;
			default: lim = 18'd160000;
		endcase
		return lim;
	endfunction

endpackage

// ----- rtl/lcr_ctrl.sv -----
// Controller state machine for the LED current range and enable block.
// Sequences capture, range search, division and commit. Uses lcr_pkg.
module lcr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lcr_pkg::sts_t sts,
	output lcr_pkg::cmd_t cmd
);

	lcr_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lcr_pkg::ST_IDLE: begin
				if (req_valid) state_nx = lcr_pkg::ST_PREP;
			end
			lcr_pkg::ST_PREP: begin
				if (!sts.is_set) state_nx = lcr_pkg::ST_FINISH;
				else if (sts.scaled) state_nx = lcr_pkg::ST_LIMIT;
				else state_nx = lcr_pkg::ST_DIV;
			end
			lcr_pkg::ST_LIMIT: state_nx = lcr_pkg::ST_CHECK;
			lcr_pkg::ST_CHECK: begin
				if (sts.below) state_nx = lcr_pkg::ST_DIV;
				else if (sts.last_idx) state_nx = lcr_pkg::ST_FINISH;
				else state_nx = lcr_pkg::ST_LIMIT;
			end
			lcr_pkg::ST_DIV: begin
				if (sts.div_done) state_nx = lcr_pkg::ST_FINISH;
			end
			lcr_pkg::ST_FINISH: begin
				if (!sts.out_busy) state_nx = lcr_pkg::ST_IDLE;
			end
			default: state_nx = lcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = (state_q != lcr_pkg::ST_IDLE);
		unique case (state_q)
			lcr_pkg::ST_IDLE: cmd.capture = req_valid;
			lcr_pkg::ST_PREP: begin
				if (sts.is_set && !sts.scaled) begin
					cmd.div_start = 1'b1;
					cmd.use_top   = 1'b1;
				end
			end
			lcr_pkg::ST_LIMIT: cmd.lim_load = 1'b1;
			lcr_pkg::ST_CHECK: begin
				if (sts.below) cmd.div_start = 1'b1;
				else if (sts.last_idx) cmd.set_err = 1'b1;
				else cmd.idx_inc = 1'b1;
			end
			lcr_pkg::ST_DIV: cmd.div_step = !sts.div_done;
			lcr_pkg::ST_FINISH: cmd.commit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	// An accepted item always moves on to decoding.
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == lcr_pkg::ST_PREP)
		else $error("accepted item did not enter decode");

	// The division runs only for set load.
	a_div_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcr_pkg::ST_DIV |-> sts.is_set)
		else $error("division running for a non set-load item");

	// A commit never overwrites a result that is still waiting.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_busy)
		else $error("commit while result register busy");

endmodule

// ----- rtl/lcr_dp.sv -----
// Datapath for the LED current range and enable block: configuration and
// state registers, range limit search, bit-serial divider, result register.
// Uses lcr_pkg; driven by lcr_ctrl commands.
module lcr_dp #(
	parameter int CODE_BITS = lcr_pkg::CODE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lcr_pkg::MULT_W-1:0] cfg_data,
	input  lcr_pkg::req_t              req,
	output lcr_pkg::rsp_t              rsp,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  lcr_pkg::cmd_t              cmd,
	output lcr_pkg::sts_t              sts
);

	localparam int DW    = CODE_BITS + lcr_pkg::LOAD_W;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int LW    = lcr_pkg::LIMIT_W;

	// Configuration.
	logic [lcr_pkg::MULT_W-1:0] mult_q;
	logic                       mode_q;

	// Architectural state.
	logic [1:0]                  flags_q;
	logic                        chip_q;
	logic [lcr_pkg::RANGE_W-1:0] rsel_q;
	logic [CODE_BITS-1:0]        left_q, right_q;

	// Per-item working registers.
	lcr_pkg::req_t               req_q;
	logic [lcr_pkg::RANGE_W-1:0] idx_q;
	logic [lcr_pkg::RANGE_W-1:0] sel_q;
	logic [LW-1:0]               lim_q;
	logic                        err_q;
	logic [LW-1:0]               den_q;
	logic [LW-1:0]               rem_q;
	logic [DW-1:0]               dvd_q;
	logic [CODE_BITS-1:0]        quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= lcr_pkg::MULT_RESET;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcr_pkg::CFG_MULT: mult_q <= cfg_data;
				lcr_pkg::CFG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Range limit: one 6x18 product registered per search step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.lim_load) begin
			lim_q <= LW'(mult_q) * LW'(lcr_pkg::base_limit(idx_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			err_q <= 1'b0;
		end else if (cmd.capture) begin
			idx_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.set_err) err_q <= 1'b1;
		end
	end

	// Restoring divider, one dividend bit per cycle; only the low quotient
	// bits are kept since the code is masked to CODE_BITS.
	logic [LW:0]   trial;
	logic [LW:0]   diff;
	logic          q_bit;
	logic [DW-1:0] dvd_init;

	assign dvd_init = {req_q.load_ua, {CODE_BITS{1'b0}}} - DW'(req_q.load_ua);
	assign trial    = {rem_q, dvd_q[DW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign q_bit    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			den_q <= cmd.use_top ? lcr_pkg::TOP_LIMIT : lim_q;
			sel_q <= cmd.use_top ? lcr_pkg::TOP_RANGE : idx_q;
			dvd_q <= dvd_init;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? diff[LW-1:0] : trial[LW-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[CODE_BITS-2:0], q_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Next architectural state and result fields.
	logic [1:0]                  bit_sel;
	logic [1:0]                  flags_nx;
	logic                        chip_nx;
	logic [lcr_pkg::RANGE_W-1:0] rsel_nx;
	logic [CODE_BITS-1:0]        left_nx, right_nx;
	lcr_pkg::power_event_t       ev;
	logic                        status;

	assign bit_sel = req_q.channel ? 2'b10 : 2'b01;

	always_comb begin
		flags_nx = flags_q;
		chip_nx  = chip_q;
		rsel_nx  = rsel_q;
		left_nx  = left_q;
		right_nx = right_q;
		ev       = lcr_pkg::PWR_NONE;
		status   = 1'b0;
		unique case (req_q.action)
			lcr_pkg::ACT_ENABLE: begin
				flags_nx = flags_q | bit_sel;
				if (flags_nx == 2'b11) begin
					chip_nx = 1'b1;
					ev      = lcr_pkg::PWR_UP;
				end
			end
			lcr_pkg::ACT_DISABLE: begin
				flags_nx = flags_q & ~bit_sel;
				if (flags_nx == 2'b00) begin
					chip_nx = 1'b0;
					ev      = lcr_pkg::PWR_DOWN;
				end
			end
			lcr_pkg::ACT_SET: begin
				if (err_q) begin
					status = 1'b1;
				end else begin
					rsel_nx = sel_q;
					if (req_q.channel) right_nx = quo_q;
					else left_nx = quo_q;
				end
			end
			lcr_pkg::ACT_QUERY: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 2'b00;
			chip_q  <= 1'b0;
			rsel_q  <= lcr_pkg::RANGE_RESET;
			left_q  <= '1;
			right_q <= '1;
		end else if (cmd.commit) begin
			flags_q <= flags_nx;
			chip_q  <= chip_nx;
			rsel_q  <= rsel_nx;
			left_q  <= left_nx;
			right_q <= right_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.status          <= status;
			rsp.range_code      <= rsel_nx;
			rsp.current_code    <= lcr_pkg::CUR_W'(req_q.channel ? right_nx : left_nx);
			rsp.channel_enabled <= req_q.channel ? flags_nx[1] : flags_nx[0];
			rsp.chip_on         <= chip_nx;
			rsp.power_event     <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	assign sts.is_set   = (req_q.action == lcr_pkg::ACT_SET);
	assign sts.scaled   = mode_q;
	assign sts.below    = (req_q.load_ua < lim_q);
	assign sts.last_idx = (idx_q == lcr_pkg::TOP_RANGE);
	assign sts.div_done = (cnt_q == CNT_W'(DW));
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	// Chip power follows the channel flags at their extremes.
	a_chip_on: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q == 2'b11 |-> chip_q)
		else $error("both channels enabled but chip off");

	a_chip_off: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q == 2'b00 |-> !chip_q)
		else $error("both channels off but chip on");

	// The partial remainder stays below the divisor while dividing.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < den_q)
		else $error("divider remainder out of range");

	// The step counter never runs past the dividend width.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DW))
		else $error("divider step count overrun");

endmodule

// ----- rtl/led_current_range_and_enable.sv -----
// Enable, disable and query results pass from the decode state to the finish
// state and are registered at commit. Set load adds, in scaled mode, a product
// and a compare per range examined, then the bit-serial divider, one dividend
// bit per cycle; unscaled set load goes straight to the divider.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is registered. Reset is asynchronous and active low; no clearing pass.
//
// The block holds two channel enable flags, a shared range selection and a
// current code per channel. In scaled mode set load searches the range table
// one entry at a time (product, then compare); set load then divides
// (2^CODE_BITS-1)*load by the chosen limit and keeps the low CODE_BITS bits.
// A scaled set load that finds no range skips the divider and reports its
// error at commit.
// The result register lets the next item be accepted while a result waits;
// commit holds off only if that register is still occupied.
module led_current_range_and_enable #(
	parameter int CODE_BITS = lcr_pkg::CODE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lcr_pkg::MULT_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lcr_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lcr_pkg::rsp_t              rsp
);

	lcr_pkg::cmd_t cmd;
	lcr_pkg::sts_t sts;

	// Controller: sequences decode, set-load search and divide, and commit.
	lcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: registers, limit multiplier, divider and result register.
	lcr_dp #(
		.CODE_BITS (CODE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- tb/led_current_range_and_enable_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for led_current_range_and_enable: its own predictor of the
// channel flags, range choice and current codes. Depends on lcr_pkg and the block's RTL.
module led_current_range_and_enable_test;
	import lcr_pkg::*;

	localparam int CODE_BITS    = CODE_BITS_DEF;
	localparam int STALL_PCT    = 20;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 200;
	localparam int QUIET_PHASE  = 5;
	localparam logic [63:0] FULL_SCALE = (64'd1 << CODE_BITS) - 64'd1;

	// Unscaled range limits in microamps, one per range code.
	localparam int unsigned RANGE_BASE [8] = '{5000, 10000, 20000, 40000,
		80000, 160000, 160000, 160000};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [MULT_W-1:0] cfg_data;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;

	led_current_range_and_enable i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Requests waiting to be driven, and the responses the predictor expects,
	// oldest first.
	req_t pending_req [$];
	rsp_t expected_rsp [$];

	// Predictor copy of the block's state and its two registers.
	logic [1:0]         chan_on;
	logic               chip_powered;
	logic [RANGE_W-1:0] range_sel;
	logic [CUR_W-1:0]   level [2];
	logic [MULT_W-1:0]  mult_reg;
	logic               scaled_mode;

	// Set while the run should have no idling on either side.
	logic quiet;

	int error_count;
	int idle_cycles;
	int req_count;
	int set_count;
	int range_errors;
	int power_events;
	int settings_used;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the response to one request and advances the predicted state.
	// A set load in scaled mode takes the first range whose scaled limit is
	// above the load; if there is none, nothing is written and status flags it.
	function automatic rsp_t predict_response(input req_t r);
		rsp_t               o;
		logic [1:0]         chan_bit;
		logic [63:0]        lim;
		logic [63:0]        code;
		logic [RANGE_W-1:0] sel;
		logic               found;
		o = '0;
		chan_bit = 2'b01 << r.channel;
		case (r.action)
			ACT_ENABLE: begin
				chan_on = chan_on | chan_bit;
				// A second enable with both already on repeats the power-up.
				if (chan_on == 2'b11) begin
					chip_powered = 1'b1;
					o.power_event = PWR_UP;
				end
			end
			ACT_DISABLE: begin
				chan_on = chan_on & ~chan_bit;
				if (chan_on == 2'b00) begin
					chip_powered = 1'b0;
					o.power_event = PWR_DOWN;
				end
			end
			ACT_SET: begin
				sel = TOP_RANGE;
				lim = 64'(RANGE_BASE[7]);
				found = 1'b1;
				if (scaled_mode) begin
					found = 1'b0;
					for (int i = 0; i < 8; i++) begin
						if (!found && 64'(r.load_ua) < 64'(mult_reg) * 64'(RANGE_BASE[i])) begin
							found = 1'b1;
							sel = RANGE_W'(i);
							lim = 64'(mult_reg) * 64'(RANGE_BASE[i]);
						end
					end
				end
				if (!found) begin
					o.status = 1'b1;
				end else begin
					// Unscaled loads above the top limit wrap: only the low bits stay.
					code = (FULL_SCALE * 64'(r.load_ua)) / lim;
					range_sel = sel;
					level[r.channel] = code[CUR_W-1:0] & FULL_SCALE[CUR_W-1:0];
				end
			end
			default: begin
			end
		endcase
		o.range_code = range_sel;
		o.current_code = level[r.channel];
		o.channel_enabled = chan_on[r.channel];
		o.chip_on = chip_powered;
		return o;
	endfunction

	// Driver: presents the next pending request once the current one is taken,
	// and now and then holds a request back at random.
	always @(posedge clk) begin
		if (arst_n && (!req_valid || !req_stall)) begin
			if (pending_req.size() != 0 && (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
				req_valid <= 1'b1;
				req <= pending_req.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side stalls at random, except during the quiet phase.
	always @(posedge clk) begin
		if (arst_n)
			rsp_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
	end

	// Every accepted request yields exactly one response, so the prediction is
	// queued at the moment of acceptance.
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			expected_rsp.push_back(predict_response(req));
			req_count++;
			if (req.action == ACT_SET)
				set_count++;
		end
	end

	function automatic void compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Monitor: each accepted response is checked against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("response with nothing expected: %h", rsp);
				error_count++;
			end else begin
				want = expected_rsp.pop_front();
				compare_field("status", want.status, rsp.status);
				compare_field("range_code", want.range_code, rsp.range_code);
				compare_field("current_code", want.current_code, rsp.current_code);
				compare_field("channel_enabled", want.channel_enabled, rsp.channel_enabled);
				compare_field("chip_on", want.chip_on, rsp.chip_on);
				compare_field("power_event", want.power_event, rsp.power_event);
				if (rsp.status)
					range_errors++;
				if (rsp.power_event != PWR_NONE)
					power_events++;
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(input action_t act, input logic chan, input int unsigned load);
		req_t r;
		r.action = act;
		r.channel = chan;
		r.load_ua = load[LOAD_W-1:0];
		pending_req.push_back(r);
	endtask

	// Writes the multiplier register, then the mode register; the block is idle by then.
	task automatic program_ranges(input logic [MULT_W-1:0] mult, input logic mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MULT;
		cfg_data <= mult;
		@(posedge clk);
		cfg_index <= CFG_MODE;
		cfg_data <= MULT_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		mult_reg = mult;
		scaled_mode = mode;
		settings_used++;
	endtask

	// Waits until every request has gone in and every response has come out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
	endtask

	// Loads lean toward the edges of the ranges under the current multiplier,
	// with a share of fully random values so every load bit toggles.
	function automatic int unsigned pick_load();
		longint v;
		longint lim;
		case ($urandom_range(0, 3))
			0: v = $urandom() & 32'hFF_FFFF;
			1: begin
				lim = longint'(mult_reg) * RANGE_BASE[$urandom_range(0, 7)];
				v = lim + $urandom_range(0, 2) - 1;
			end
			2: v = $urandom_range(0, mult_reg * 160000 + 1000);
			default: v = $urandom_range(0, 5000);
		endcase
		if (v < 0)
			v = 0;
		if (v > 24'hFF_FFFF)
			v = 24'hFF_FFFF;
		return int'(v);
	endfunction

	task automatic queue_random(input int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 9);
			if (roll < 4)
				push_item(ACT_SET, 1'($urandom_range(0, 1)), pick_load());
			else if (roll < 6)
				push_item(ACT_ENABLE, 1'($urandom_range(0, 1)), $urandom());
			else if (roll < 8)
				push_item(ACT_DISABLE, 1'($urandom_range(0, 1)), $urandom());
			else
				push_item(ACT_QUERY, 1'($urandom_range(0, 1)), $urandom());
		end
	endtask

	initial begin
		logic [MULT_W-1:0] mult;
		logic              mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MULT;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		quiet = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		req_count = 0;
		set_count = 0;
		range_errors = 0;
		power_events = 0;
		settings_used = 1;
		// Predicted state after reset: everything off, range 3, full-scale codes.
		chan_on = 2'b00;
		chip_powered = 1'b0;
		range_sel = RANGE_RESET;
		level[0] = FULL_SCALE[CUR_W-1:0];
		level[1] = FULL_SCALE[CUR_W-1:0];
		mult_reg = MULT_RESET;
		scaled_mode = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings: state after reset, the power
		// sequencing including repeated sequences, and unscaled set loads with
		// loads past the top limit that wrap the code.
		push_item(ACT_QUERY, 1'b0, 0);
		push_item(ACT_QUERY, 1'b1, 24'hFF_FFFF);
		push_item(ACT_ENABLE, 1'b0, 0);
		push_item(ACT_ENABLE, 1'b1, 0);
		push_item(ACT_ENABLE, 1'b1, 0);
		push_item(ACT_SET, 1'b0, 0);
		push_item(ACT_SET, 1'b1, 24'hFF_FFFF);
		push_item(ACT_SET, 1'b0, 160000);
		push_item(ACT_SET, 1'b1, 159999);
		push_item(ACT_DISABLE, 1'b0, 0);
		push_item(ACT_DISABLE, 1'b1, 0);
		push_item(ACT_DISABLE, 1'b1, 0);
		wait_drained();

		// A zero multiplier makes every scaled limit zero: set load always errors
		// and the reply still carries the untouched state.
		program_ranges('0, 1'b1);
		push_item(ACT_SET, 1'b0, 0);
		push_item(ACT_SET, 1'b1, 24'hFF_FFFF);
		push_item(ACT_QUERY, 1'b0, 0);
		wait_drained();

		// Multiplier of 60: range edges, the top limit and loads beyond it.
		program_ranges(6'd60, 1'b1);
		push_item(ACT_SET, 1'b0, 0);
		push_item(ACT_SET, 1'b0, 299999);
		push_item(ACT_SET, 1'b1, 300000);
		push_item(ACT_SET, 1'b0, 9599999);
		push_item(ACT_SET, 1'b1, 9600000);
		push_item(ACT_SET, 1'b1, 24'hFF_FFFF);
		push_item(ACT_SET, 1'b1, 4999);
		wait_drained();

		// Random phases, each under its own register setting. One phase runs
		// with no idling on either side.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin mult = 6'd1;  mode = 1'b0; end
				1: begin mult = 6'd60; mode = 1'b1; end
				2: begin mult = 6'd1;  mode = 1'b1; end
				3: begin mult = '0;    mode = 1'b1; end
				default: begin
					mult = MULT_W'($urandom_range(1, 60));
					mode = 1'($urandom_range(0, 1));
				end
			endcase
			program_ranges(mult, mode);
			quiet = (p == QUIET_PHASE);
			queue_random(PHASE_ITEMS);
			wait_drained();
			quiet = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests (%0d set loads, %0d range errors, %0d power events)",
			req_count, set_count, range_errors, power_events);
		$display("under %0d register settings, with random stalls on both sides.",
			settings_used);
		if (error_count == 0 && expected_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lcr_pkg.sv
rtl/lcr_ctrl.sv
rtl/lcr_dp.sv
rtl/led_current_range_and_enable.sv
tb/led_current_range_and_enable_test.sv
